>>> src/pidti_pkg.sv
// Shared types, constants and the microcode program of the PID trapezoid-integral controller.
package pidti_pkg;

   // ---------------------------------------------------------------
   // Item and configuration types
   // ---------------------------------------------------------------
   typedef struct packed {
      logic              kind;
      logic signed [31:0] meas_pos;
      logic signed [31:0] meas_rate;
      logic signed [31:0] time_ms;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic              drive_valid;
   } rsp_item_type;

   typedef struct packed {
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic signed [31:0] target_pos;
      logic signed [31:0] target_rate;
      logic              target_enabled;
   } cfg_type;

   // Register indexes of the configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_POS     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_RATE    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_ENABLED = 3'd5;

   // Item kind codes
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // ---------------------------------------------------------------
   // Shared multiplier
   // ---------------------------------------------------------------
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // ceil(2^35 / 125): floor(x * RECIP_125 / 2^35) == floor(x / 125) for x < 2^28
   localparam int RECIP_SHIFT = 35;
   localparam logic [28:0] RECIP_125 = 29'd274877907;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
      logic               neg;
   } mul_req_type;

   // ---------------------------------------------------------------
   // Control word
   // ---------------------------------------------------------------
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_DT_RECIP,
      MUL_SM_Q,
      MUL_SM_R,
      MUL_A_RECIP,
      MUL_CUR_RECIP,
      MUL_P,
      MUL_D,
      MUL_I_HI,
      MUL_I_LO
   } mul_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ERR,
      OP_SUM,
      OP_QDT,
      OP_RDT,
      OP_INC_HI,
      OP_LOWY,
      OP_REMA,
      OP_ADDT,
      OP_INTEG,
      OP_FIRST,
      OP_RESTART,
      OP_TERM,
      OP_HI,
      OP_TERM_WIDE
   } dp_op_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_RESTART,
      COND_NO_TARGET,
      COND_NO_PREV
   } cond_type;

   localparam int STEP_W = 5;

   typedef struct packed {
      mul_sel_type       mul_sel;
      dp_op_type         dp_op;
      acc_op_type        acc_op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ctl_word_type;

   // Status flags the sequencer branches on
   typedef struct packed {
      logic restart;
      logic no_target;
      logic no_prev;
   } flags_type;

   // Program addresses
   localparam logic [STEP_W-1:0] ST_DISPATCH = 5'd0;
   localparam logic [STEP_W-1:0] ST_ERR      = 5'd1;
   localparam logic [STEP_W-1:0] ST_SUM      = 5'd2;
   localparam logic [STEP_W-1:0] ST_QDT      = 5'd3;
   localparam logic [STEP_W-1:0] ST_RDT      = 5'd4;
   localparam logic [STEP_W-1:0] ST_INC_HI   = 5'd5;
   localparam logic [STEP_W-1:0] ST_LOWY     = 5'd6;
   localparam logic [STEP_W-1:0] ST_DIVA     = 5'd7;
   localparam logic [STEP_W-1:0] ST_REMA     = 5'd8;
   localparam logic [STEP_W-1:0] ST_DIVB     = 5'd9;
   localparam logic [STEP_W-1:0] ST_ADDT     = 5'd10;
   localparam logic [STEP_W-1:0] ST_INTEG    = 5'd11;
   localparam logic [STEP_W-1:0] ST_FIRST    = 5'd12;
   localparam logic [STEP_W-1:0] ST_U0       = 5'd13;
   localparam logic [STEP_W-1:0] ST_U1       = 5'd14;
   localparam logic [STEP_W-1:0] ST_U2       = 5'd15;
   localparam logic [STEP_W-1:0] ST_U3       = 5'd16;
   localparam logic [STEP_W-1:0] ST_U4       = 5'd17;
   localparam logic [STEP_W-1:0] ST_U5       = 5'd18;
   localparam logic [STEP_W-1:0] ST_OUT      = 5'd19;
   localparam logic [STEP_W-1:0] ST_RST      = 5'd20;

   localparam logic [STEP_W-1:0] ST_ZERO = '0;

   localparam ctl_word_type CTL_IDLE = '{
      mul_sel: MUL_NONE, dp_op: OP_NONE, acc_op: ACC_NONE,
      cond: COND_NEVER, target: ST_ZERO, last: 1'b0
   };

   function automatic ctl_word_type cw(input mul_sel_type m, input dp_op_type op,
                                       input acc_op_type acc, input cond_type c,
                                       input logic [STEP_W-1:0] tgt, input logic last);
      ctl_word_type w;
      w.mul_sel = m;
      w.dp_op   = op;
      w.acc_op  = acc;
      w.cond    = c;
      w.target  = tgt;
      w.last    = last;
      return w;
   endfunction

   // Microcode program, one control word per step
   function automatic ctl_word_type ucode(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      unique case (step)
         ST_DISPATCH: w = cw(MUL_NONE, OP_NONE, ACC_NONE, COND_RESTART, ST_RST, 1'b0);
         ST_ERR:      w = cw(MUL_NONE, OP_ERR, ACC_NONE, COND_NO_TARGET, ST_U0, 1'b0);
         ST_SUM:      w = cw(MUL_DT_RECIP, OP_SUM, ACC_NONE, COND_NO_PREV, ST_FIRST, 1'b0);
         ST_QDT:      w = cw(MUL_NONE, OP_QDT, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_RDT:      w = cw(MUL_SM_Q, OP_RDT, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_INC_HI:   w = cw(MUL_SM_R, OP_INC_HI, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_LOWY:     w = cw(MUL_NONE, OP_LOWY, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_DIVA:     w = cw(MUL_A_RECIP, OP_NONE, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_REMA:     w = cw(MUL_NONE, OP_REMA, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_DIVB:     w = cw(MUL_CUR_RECIP, OP_NONE, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_ADDT:     w = cw(MUL_NONE, OP_ADDT, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_INTEG:    w = cw(MUL_NONE, OP_INTEG, ACC_NONE, COND_ALWAYS, ST_U0, 1'b0);
         ST_FIRST:    w = cw(MUL_NONE, OP_FIRST, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_U0:       w = cw(MUL_P, OP_NONE, ACC_NONE, COND_NO_PREV, ST_OUT, 1'b0);
         ST_U1:       w = cw(MUL_D, OP_TERM, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_U2:       w = cw(MUL_I_HI, OP_TERM, ACC_LOAD, COND_NEVER, ST_ZERO, 1'b0);
         ST_U3:       w = cw(MUL_I_LO, OP_HI, ACC_ADD, COND_NEVER, ST_ZERO, 1'b0);
         ST_U4:       w = cw(MUL_NONE, OP_TERM_WIDE, ACC_NONE, COND_NEVER, ST_ZERO, 1'b0);
         ST_U5:       w = cw(MUL_NONE, OP_NONE, ACC_ADD, COND_NEVER, ST_ZERO, 1'b0);
         ST_OUT:      w = cw(MUL_NONE, OP_NONE, ACC_NONE, COND_NEVER, ST_ZERO, 1'b1);
         ST_RST:      w = cw(MUL_NONE, OP_RESTART, ACC_NONE, COND_ALWAYS, ST_OUT, 1'b0);
         default:     w = cw(MUL_NONE, OP_NONE, ACC_NONE, COND_NEVER, ST_ZERO, 1'b1);
      endcase
      return w;
   endfunction

endpackage

>>> src/pidti_mul.sv
// Shared unsigned multiplier with registered product and sign.
module pidti_mul (
   input  logic                                clock,
   input  pidti_pkg::mul_req_type              mul_req,
   output logic [pidti_pkg::MUL_P_W-1:0]       prod,
   output logic                                prod_neg
);
   import pidti_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;
   logic               neg_ff;

   assign prod_in = MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);

   // product holds until the next issued multiply
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
         neg_ff  <= mul_req.neg;
      end
   end

   assign prod     = prod_ff;
   assign prod_neg = neg_ff;

endmodule

>>> src/pidti_seq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
module pidti_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    out_free,
   input  pidti_pkg::flags_type    flags,
   output pidti_pkg::ctl_word_type ctl,
   output logic                    busy,
   output logic                    done
);
   import pidti_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ctl_word_type      word;
   logic              take;

   assign word = ucode(step_ff);

   // branch condition
   always_comb begin
      unique case (word.cond)
         COND_NEVER:     take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_RESTART:   take = flags.restart;
         COND_NO_TARGET: take = flags.no_target;
         COND_NO_PREV:   take = flags.no_prev;
         default:        take = 1'b0;
      endcase
   end

   // last step waits for a free output register
   assign done = busy_ff && word.last && out_free;
   assign ctl  = busy_ff ? word : CTL_IDLE;
   assign busy = busy_ff;

   // next step
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = ST_DISPATCH;
         end
      end else if (word.last) begin
         if (out_free) begin
            busy_in = 1'b0;
         end
      end else if (take) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ST_DISPATCH;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

`ifndef ASSERT_OFF
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= ST_RST))
      else $error("sequencer step outside the program");
   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && start) |=> (busy_ff && step_ff == ST_DISPATCH))
      else $error("start did not enter the dispatch step");
   a_jump_target: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !word.last && take) |=> (step_ff == $past(word.target)))
      else $error("taken jump missed its target");
`endif

endmodule

>>> src/pidti_dp.sv
// Datapath: errors, trapezoid integral step, control sum and controller state.
module pidti_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pidti_pkg::ctl_word_type             ctl,
   input  pidti_pkg::cfg_type                  cfg,
   input  pidti_pkg::req_item_type             item,
   input  logic [pidti_pkg::MUL_P_W-1:0]       prod,
   input  logic                                prod_neg,
   output pidti_pkg::mul_req_type              mul_req,
   output logic                                have_prev,
   output pidti_pkg::rsp_item_type             result
);
   import pidti_pkg::*;

   // controller state
   logic               have_prev_ff;
   logic signed [31:0] prev_error_ff;
   logic signed [31:0] rate_error_ff;
   logic signed [47:0] integral_ff;
   logic signed [31:0] last_time_ff;

   // work registers
   logic [31:0] enew_ff;
   logic [31:0] edot_ff;
   logic [31:0] udt_ff;
   logic        sum_neg_ff;
   logic [32:0] sm_ff;
   logic [20:0] q_ff;
   logic [10:0] r_ff;
   logic [53:0] inc_ff;
   logic [39:0] x_ff;
   logic [12:0] qa_ff;
   logic [26:0] cur_ff;
   logic [55:0] hi_ff;
   logic [62:0] term_ff;
   logic        term_neg_ff;
   logic [63:0] uacc_ff;

   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   // ---- error and time differences ----
   logic [32:0] d_pos, d_rate, d_time;
   assign d_pos  = {cfg.target_pos[31], cfg.target_pos} - {item.meas_pos[31], item.meas_pos};
   assign d_rate = {cfg.target_rate[31], cfg.target_rate}
                   - {item.meas_rate[31], item.meas_rate};
   assign d_time = {item.time_ms[31], item.time_ms} - {last_time_ff[31], last_time_ff};

   // ---- sum of old and new error ----
   logic [32:0] sum33;
   assign sum33 = {enew_ff[31], enew_ff} + {prev_error_ff[31], prev_error_ff};

   // ---- dt split into multiples of 2000 and remainder ----
   logic [31:0] q2000;
   assign q2000 = {q_ff, 11'd0} - {6'd0, q_ff, 5'd0} - {7'd0, q_ff, 4'd0};

   // ---- long division by 125 of the low part, 20 bits a digit ----
   logic [12:0] qa;
   logic [19:0] qa125;
   logic [19:0] ra;
   logic [19:0] q2;
   assign qa    = prod[RECIP_SHIFT+12:RECIP_SHIFT];
   assign qa125 = {qa, 7'd0} - {6'd0, qa, 1'b0} - {7'd0, qa};
   assign ra    = x_ff[39:20] - qa125;
   assign q2    = prod[RECIP_SHIFT+19:RECIP_SHIFT];

   // ---- integral update with 48-bit saturation ----
   logic [55:0] inc_signed, acc56;
   logic [47:0] integ_sat;
   assign inc_signed = sum_neg_ff ? (56'd0 - {2'd0, inc_ff}) : {2'd0, inc_ff};
   assign acc56      = {{8{integral_ff[47]}}, integral_ff} + inc_signed;
   assign integ_sat  = (acc56[55:47] != {9{acc56[55]}})
                       ? (acc56[55] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)
                       : acc56[47:0];

   // ---- product rounding to Q16.16 ----
   logic [63:0] rnd_full;
   logic [47:0] rnd;
   logic [62:0] wide_term;
   assign rnd_full  = prod[63:0] + 64'h8000;
   assign rnd       = rnd_full[63:16];
   assign wide_term = 63'({hi_ff, 8'd0}) + 63'(rnd);

   // ---- control sum ----
   logic [63:0] term_signed;
   assign term_signed = term_neg_ff ? (64'd0 - {1'b0, term_ff}) : {1'b0, term_ff};

   logic [47:0] integ_mag;
   assign integ_mag = integral_ff[47] ? (48'd0 - integral_ff) : integral_ff;

   // ---- multiplier operand select ----
   always_comb begin
      mul_req = '0;
      unique case (ctl.mul_sel)
         MUL_NONE: mul_req.en = 1'b0;
         MUL_DT_RECIP: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(udt_ff[31:4]);
            mul_req.b  = MUL_B_W'(RECIP_125);
         end
         MUL_SM_Q: begin
            mul_req.en = 1'b1;
            mul_req.a  = sm_ff;
            mul_req.b  = MUL_B_W'(q_ff);
         end
         MUL_SM_R: begin
            mul_req.en = 1'b1;
            mul_req.a  = sm_ff;
            mul_req.b  = MUL_B_W'(r_ff);
         end
         MUL_A_RECIP: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(x_ff[39:20]);
            mul_req.b  = MUL_B_W'(RECIP_125);
         end
         MUL_CUR_RECIP: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(cur_ff);
            mul_req.b  = MUL_B_W'(RECIP_125);
         end
         MUL_P: begin
            mul_req.en  = 1'b1;
            mul_req.a   = MUL_A_W'(mag32(cfg.gain_p));
            mul_req.b   = mag32(prev_error_ff);
            mul_req.neg = cfg.gain_p[31] ^ prev_error_ff[31];
         end
         MUL_D: begin
            mul_req.en  = 1'b1;
            mul_req.a   = MUL_A_W'(mag32(cfg.gain_d));
            mul_req.b   = mag32(rate_error_ff);
            mul_req.neg = cfg.gain_d[31] ^ rate_error_ff[31];
         end
         MUL_I_HI: begin
            mul_req.en  = 1'b1;
            mul_req.a   = MUL_A_W'(mag32(cfg.gain_i));
            mul_req.b   = MUL_B_W'(integ_mag[47:24]);
            mul_req.neg = cfg.gain_i[31] ^ integral_ff[47];
         end
         MUL_I_LO: begin
            mul_req.en  = 1'b1;
            mul_req.a   = MUL_A_W'(mag32(cfg.gain_i));
            mul_req.b   = MUL_B_W'(integ_mag[23:0]);
            mul_req.neg = cfg.gain_i[31] ^ integral_ff[47];
         end
         default: mul_req.en = 1'b0;
      endcase
   end

   // ---- validity flag ----
   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (ctl.dp_op == OP_FIRST) begin
         have_prev_ff <= 1'b1;
      end else if (ctl.dp_op == OP_RESTART) begin
         have_prev_ff <= 1'b0;
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         prev_error_ff <= '0;
         rate_error_ff <= '0;
         last_time_ff  <= '0;
      end else begin
         unique case (ctl.dp_op)
            OP_NONE: begin
            end
            OP_ERR: begin
               enew_ff <= sat33(d_pos);
               edot_ff <= sat33(d_rate);
               udt_ff  <= d_time[32] ? 32'd0 : d_time[31:0];
            end
            OP_SUM: begin
               sum_neg_ff <= sum33[32];
               sm_ff      <= sum33[32] ? (33'd0 - sum33) : sum33;
            end
            OP_QDT: q_ff <= prod[RECIP_SHIFT+20:RECIP_SHIFT];
            OP_RDT: begin
               r_ff <= 11'(udt_ff - q2000);
            end
            OP_INC_HI: inc_ff <= prod[53:0];
            OP_LOWY: x_ff <= 40'((prod[43:0] + 44'd1000) >> 4);
            OP_REMA: begin
               qa_ff  <= qa;
               cur_ff <= {ra[6:0], x_ff[19:0]};
            end
            OP_ADDT: inc_ff <= inc_ff + 54'({qa_ff, q2});
            OP_INTEG: begin
               integral_ff   <= integ_sat;
               prev_error_ff <= enew_ff;
               rate_error_ff <= edot_ff;
               last_time_ff  <= item.time_ms;
            end
            OP_FIRST: begin
               integral_ff   <= '0;
               prev_error_ff <= enew_ff;
               rate_error_ff <= edot_ff;
               last_time_ff  <= item.time_ms;
            end
            OP_RESTART: begin
               integral_ff   <= '0;
               prev_error_ff <= '0;
               rate_error_ff <= '0;
            end
            OP_TERM: begin
               term_ff     <= 63'(rnd);
               term_neg_ff <= prod_neg;
            end
            OP_HI: hi_ff <= prod[55:0];
            OP_TERM_WIDE: begin
               term_ff     <= wide_term;
               term_neg_ff <= prod_neg;
            end
            default: begin
            end
         endcase
      end
   end

   // ---- control accumulator ----
   always_ff @(posedge clock) begin
      unique case (ctl.acc_op)
         ACC_NONE: begin
         end
         ACC_LOAD: uacc_ff <= term_signed;
         ACC_ADD:  uacc_ff <= uacc_ff + term_signed;
         default: begin
         end
      endcase
   end

   // ---- result ----
   logic [31:0] drive_sat;
   assign drive_sat = (uacc_ff[63:31] != {33{uacc_ff[63]}})
                      ? (uacc_ff[63] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      : uacc_ff[31:0];

   assign result.drive       = have_prev_ff ? drive_sat : 32'd0;
   assign result.drive_valid = have_prev_ff;
   assign have_prev          = have_prev_ff;

`ifndef ASSERT_OFF
   a_valid_set_by_first: assert property (@(posedge clock) disable iff (reset)
      $rose(have_prev_ff) |-> $past(ctl.dp_op == OP_FIRST))
      else $error("validity set outside the first-update step");
   a_valid_cleared_by_restart: assert property (@(posedge clock) disable iff (reset)
      $fell(have_prev_ff) |-> $past(ctl.dp_op == OP_RESTART))
      else $error("validity cleared outside a restart");
   a_integral_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      (ctl.dp_op == OP_INTEG) |-> have_prev_ff)
      else $error("integral step without a valid state");
`endif

endmodule

>>> src/pid_trapezoid_integral_controller_core.sv
// Top level of the PID trapezoid-integral controller: ports, registers, item and result stages.
//
//   channel  ports                               direction  transfer
//   req      req_valid req_ready req_item        in         valid/ready, one item
//   rsp      rsp_valid rsp_ready rsp_item        out        valid/ready, one result per item
//   csr      csr_we csr_addr csr_wdata           in         write on csr_we, no wait
//
// One item at a time. After acceptance the microcode runs the whole program for a measurement
// with history, skips the integral step for the first measurement, skips the state update
// when the target is disabled (and the control sum too without a valid state), and only
// clears the state for a restart; the next item is taken in the cycle after the result
// is loaded. The program is built around the single shared 33x32 multiplier.
// Reset (synchronous, active high) clears settings, controller state, validity and both handshakes.
// A result waiting on rsp_ready holds the sequencer on its last step.
module pid_trapezoid_integral_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pidti_pkg::req_item_type              req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pidti_pkg::rsp_item_type              rsp_item,
   input  logic                                 csr_we,
   input  logic [pidti_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pidti_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pidti_pkg::*;

   cfg_type      cfg_ff;
   req_item_type item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   ctl_word_type            ctl;
   flags_type               flags;
   mul_req_type             mul_req;
   logic [MUL_P_W-1:0]      prod;
   logic                    prod_neg;
   logic                    busy, done, start, out_free, have_prev;
   rsp_item_type            result;

   assign start     = req_valid && req_ready;
   assign req_ready = !busy && !reset;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GAIN_P:         cfg_ff.gain_p         <= csr_wdata;
            CSR_GAIN_I:         cfg_ff.gain_i         <= csr_wdata;
            CSR_GAIN_D:         cfg_ff.gain_d         <= csr_wdata;
            CSR_TARGET_POS:     cfg_ff.target_pos     <= csr_wdata;
            CSR_TARGET_RATE:    cfg_ff.target_rate    <= csr_wdata;
            CSR_TARGET_ENABLED: cfg_ff.target_enabled <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= req_item;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign flags.restart   = (item_ff.kind == KIND_RESTART);
   assign flags.no_target = !cfg_ff.target_enabled;
   assign flags.no_prev   = !have_prev;

   pidti_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .flags    (flags),
      .ctl      (ctl),
      .busy     (busy),
      .done     (done)
   );

   pidti_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .prod     (prod),
      .prod_neg (prod_neg)
   );

   pidti_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .item      (item_ff),
      .prod      (prod),
      .prod_neg  (prod_neg),
      .mul_req   (mul_req),
      .have_prev (have_prev),
      .result    (result)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while an item is in work");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !done)
      else $error("pending result overwritten");
   a_invalid_drive_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.drive_valid) |-> (rsp_item_ff.drive == 32'sd0))
      else $error("nonzero drive without a valid state");
`endif

endmodule
